// ----- src/sorted_array_priority_queue_macros.svh -----
// Assertion macros for the sorted array priority queue.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked outside reset
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- src/spq_pkg.sv -----
// Shared types, codes and helpers of the sorted array priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEPTH_DFLT = 16;
  localparam int KEY_W      = 32;
  localparam int PAYLOAD_W  = 16;
  localparam int STATUS_W   = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic ORDER_MAX_FIRST = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic   ins_en;
    logic   rem_en;
    logic   order_mode;
    entry_t entry;
  } cell_ctrl_t;

  // true when key a is served before key b
  function automatic logic goes_ahead(input logic order_mode,
                                      input logic [KEY_W-1:0] a,
                                      input logic [KEY_W-1:0] b);
    logic res;
    if (order_mode == ORDER_MAX_FIRST) res = (a > b);
    else res = (a < b);
    return res;
  endfunction

endpackage

// ----- src/spq_cell.sv -----
// One slot of the sorted queue: holds an entry, compares, shifts with neighbors.
`timescale 1ns / 1ps

module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                occ,        // slot holds a live entry
  input  logic                at_tail,    // slot is the first free one
  input  logic                shift,      // slot moves its entry back
  input  logic                prev_shift, // slot ahead moves its entry back
  input  spq_pkg::entry_t     prev_ent,
  input  spq_pkg::entry_t     next_ent,
  output logic                beats,      // new key goes ahead of the held one
  output spq_pkg::entry_t     ent
);

  spq_pkg::entry_t ent_r;
  spq_pkg::entry_t ent_nxt;

  assign beats = occ && spq_pkg::goes_ahead(ctrl.order_mode, ctrl.entry.key, ent_r.key);
  assign ent   = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.ins_en) begin
      if (prev_shift) ent_nxt = prev_ent;
      else if (shift || at_tail) ent_nxt = ctrl.entry;
    end else if (ctrl.rem_en) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ----- src/sorted_array_priority_queue.sv -----
// Top level of the sorted array priority queue: cell row, count and handshakes.
`timescale 1ns / 1ps

// Bounded priority queue of DEPTH entries (32-bit key, 16-bit payload),
// kept sorted in a row of cells with the head in cell 0. Every cell
// compares the incoming key with its own in parallel; an insert moves the
// unbroken run of entries at the tail that the new key beats back one cell
// and drops the new entry into the gap, behind any equal keys, so equal
// keys leave in arrival order. A remove returns cell 0 and moves every
// entry forward one cell. Each transfer on the in_ channel yields exactly
// one registered transfer on the out_ channel: status (done, insert
// dropped because full, remove on empty), the removed key and payload
// (zero otherwise) and the fill count afterwards. One item per clock is
// taken while the result register is empty or being drained; the cycle is
// set by one 32-bit compare per cell, a run of ANDs back from the tail
// across the row and the neighbor select. cfg_data bit picks the order:
// 0 largest key first, 1 smallest key first. Write it only while the queue
// channel is quiet; entries already held keep their places. Reset empties
// the queue and selects largest first.

`include "sorted_array_priority_queue_macros.svh"

module sorted_array_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DFLT,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [spq_pkg::KEY_W-1:0]     in_key,
  input  logic [spq_pkg::PAYLOAD_W-1:0] in_payload,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spq_pkg::STATUS_W-1:0]  out_status,
  output logic [spq_pkg::KEY_W-1:0]     out_head_key,
  output logic [spq_pkg::PAYLOAD_W-1:0] out_head_payload,
  output logic [CNT_W-1:0]              out_fill_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic             order_mode_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  spq_pkg::status_t status_r;
  spq_pkg::status_t status_nxt;
  spq_pkg::entry_t  head_r;
  spq_pkg::entry_t  head_nxt;

  logic in_fire;
  logic is_full;
  logic is_empty;
  spq_pkg::cell_ctrl_t ctrl;

  // neighbor links of the cell row
  logic            beats_w [DEPTH];
  logic            shift_w [DEPTH];
  spq_pkg::entry_t ent_w   [DEPTH];

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign is_full   = (count_r == FULL_CNT);
  assign is_empty  = (count_r == '0);

  assign ctrl.ins_en     = in_fire && (in_cmd == spq_pkg::CMD_INSERT) && !is_full;
  assign ctrl.rem_en     = in_fire && (in_cmd == spq_pkg::CMD_REMOVE) && !is_empty;
  assign ctrl.order_mode = order_mode_r;
  assign ctrl.entry      = '{key: in_key, payload: in_payload};

  // a cell moves back only while every live cell behind it is beaten too;
  // the first entry the new key does not beat stops the run
  always_comb begin : shift_select
    logic tail_run;
    tail_run = 1'b1;
    for (int j = DEPTH - 1; j >= 0; j--) begin
      if (count_r > CNT_W'(j)) tail_run = tail_run && beats_w[j];
      shift_w[j] = tail_run && (count_r > CNT_W'(j));
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (count_r > CNT_W'(i)),
      .at_tail    (count_r == CNT_W'(i)),
      .shift      (shift_w[i]),
      .prev_shift ((i == 0) ? 1'b0 : shift_w[(i == 0) ? 0 : i - 1]),
      .prev_ent   (ent_w[(i == 0) ? 0 : i - 1]),
      .next_ent   ((i == DEPTH - 1) ? '0 : ent_w[(i == DEPTH - 1) ? i : i + 1]),
      .beats      (beats_w[i]),
      .ent        (ent_w[i])
    );
  end

  // result and count for the item taken this cycle
  always_comb begin
    count_nxt  = count_r;
    status_nxt = spq_pkg::ST_DONE;
    head_nxt   = '0;
    if (in_cmd == spq_pkg::CMD_INSERT) begin
      if (is_full) status_nxt = spq_pkg::ST_FULL;
      else count_nxt = count_r + CNT_W'(1);
    end else begin
      if (is_empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else begin
        head_nxt  = ent_w[0];
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_mode_r <= spq_pkg::ORDER_MAX_FIRST;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) order_mode_r <= cfg_data;
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      head_r   <= head_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_head_key     = head_r.key;
  assign out_head_payload = head_r.payload;
  assign out_fill_count   = count_r;

  `SPQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= FULL_CNT, "fill count past depth")
  `SPQ_ASSERT_NEXT(a_full_drop, clk, rst_n, in_fire && (in_cmd == spq_pkg::CMD_INSERT) && is_full, (status_r == spq_pkg::ST_FULL) && (count_r == $past(count_r)), "full insert not dropped")
  `SPQ_ASSERT_NEXT(a_remove_count, clk, rst_n, ctrl.rem_en, (count_r == $past(count_r) - CNT_W'(1)) && (status_r == spq_pkg::ST_DONE), "remove did not shrink queue")
  `SPQ_ASSERT_NEXT(a_empty_zero, clk, rst_n, in_fire && (in_cmd == spq_pkg::CMD_REMOVE) && is_empty, (status_r == spq_pkg::ST_EMPTY) && (head_r == '0), "empty remove result wrong")

endmodule
